// ----- sv/quaternion_to_rotation_matrix_unit_macros.svh -----
// assertion macros shared by the quaternion to rotation matrix rtl
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define QRM_ASSERT_NEVER(lbl, clk, rst_n, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);

`endif

// ----- sv/qrm_pkg.sv -----
// package with widths, types and helpers of the quaternion to rotation matrix unit
package qrm_pkg;

    localparam int QW           = 16;
    localparam int TW           = 32;
    localparam int PW           = 32;
    localparam int LW           = 33;
    localparam int NW           = 34;
    localparam int EW           = LW + 1;
    localparam int QB           = 15;
    localparam int DW           = NW - 1 + QB + 1;
    localparam int N_ENT        = 9;
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = QB;
    localparam int SIDE_LAT     = FRONT_STAGES + DIV_STAGES;

    localparam logic [QW-1:0] ONE_Q14 = QW'(16384);

    typedef struct packed {
        logic neg;
        logic zero;
    } t_tag;

    typedef struct packed {
        logic [TW-1:0] x;
        logic [TW-1:0] y;
        logic [TW-1:0] z;
    } t_trans;

    // signed entry from rounded magnitude, always in range for 15 bit magnitudes
    function automatic logic [QW-1:0] to_q14(input logic [QB-1:0] q, input logic neg);
        logic [QW-1:0] m;
        m = {1'b0, q};
        return neg ? (QW'(0) - m) : m;
    endfunction

endpackage

// ----- sv/qrm_front.sv -----
// front end: products, squared length, numerators and dividend set-up
module qrm_front
    import qrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [QW-1:0] i_quat_x,
    input  logic signed [QW-1:0] i_quat_y,
    input  logic signed [QW-1:0] i_quat_z,
    input  logic signed [QW-1:0] i_quat_w,
    output logic                 o_valid,
    output logic [DW-1:0]        o_num [N_ENT],
    output logic [EW-1:0]        o_den,
    output t_tag                 o_tag [N_ENT]
);

    function automatic logic signed [NW-1:0] sx(input logic signed [PW-1:0] v);
        return {{(NW-PW){v[PW-1]}}, v};
    endfunction

    // stage 1: squares and cross products
    logic                 r_v1;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ww;
    logic signed [PW-1:0] r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;

    // stage 2: length and numerators
    logic                 r_v2;
    logic [LW-1:0]        r_len;
    logic                 r_zero;
    logic signed [NW-1:0] r_n [N_ENT];
    logic [LW-1:0]        n_len;
    logic signed [NW-1:0] n_n [N_ENT];

    // stage 3: dividend, divisor, sign
    logic                 r_v3;
    logic [DW-1:0]        r_num [N_ENT];
    logic [EW-1:0]        r_den;
    t_tag                 r_tag [N_ENT];

    always_comb begin
        n_len = {1'b0, r_xx} + {1'b0, r_yy} + {1'b0, r_zz} + {1'b0, r_ww};
        n_n[0] = sx(r_xx) + sx(r_ww) - sx(r_yy) - sx(r_zz);
        n_n[1] = (sx(r_xy) - sx(r_zw)) <<< 1;
        n_n[2] = (sx(r_xz) + sx(r_yw)) <<< 1;
        n_n[3] = (sx(r_xy) + sx(r_zw)) <<< 1;
        n_n[4] = sx(r_yy) + sx(r_ww) - sx(r_xx) - sx(r_zz);
        n_n[5] = (sx(r_yz) - sx(r_xw)) <<< 1;
        n_n[6] = (sx(r_xz) - sx(r_yw)) <<< 1;
        n_n[7] = (sx(r_yz) + sx(r_xw)) <<< 1;
        n_n[8] = sx(r_zz) + sx(r_ww) - sx(r_xx) - sx(r_yy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] mag;
        if (i_en) begin
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_ww <= i_quat_w * i_quat_w;
            r_xy <= i_quat_x * i_quat_y;
            r_zw <= i_quat_z * i_quat_w;
            r_xz <= i_quat_x * i_quat_z;
            r_yw <= i_quat_y * i_quat_w;
            r_yz <= i_quat_y * i_quat_z;
            r_xw <= i_quat_x * i_quat_w;

            r_len  <= n_len;
            r_zero <= (n_len == '0);
            for (int k = 0; k < N_ENT; k++) begin
                r_n[k] <= n_n[k];
            end

            // dividend carries the half-divisor for round to nearest
            r_den <= {r_len, 1'b0};
            for (int k = 0; k < N_ENT; k++) begin
                mag = r_n[k][NW-1] ? (NW'(0) - NW'(r_n[k])) : NW'(r_n[k]);
                r_num[k]      <= (DW'(mag[NW-2:0]) << QB) + DW'(r_len);
                r_tag[k].neg  <= r_n[k][NW-1];
                r_tag[k].zero <= r_zero;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_tag   = r_tag;

endmodule

// ----- sv/qrm_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`include "quaternion_to_rotation_matrix_unit_macros.svh"

module qrm_div
    import qrm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [EW-1:0] i_den,
    input  t_tag          i_tag,
    output logic          o_valid,
    output logic [QB-1:0] o_quo,
    output t_tag          o_tag
);

    logic          r_valid [1:DIV_STAGES];
    logic [DW-1:0] r_rem   [1:DIV_STAGES];
    logic [EW-1:0] r_den   [1:DIV_STAGES];
    logic [QB-1:0] r_quo   [1:DIV_STAGES];
    t_tag          r_tag   [1:DIV_STAGES];

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
        logic          w_valid;
        logic [DW-1:0] w_rem;
        logic [EW-1:0] w_den;
        logic [QB-1:0] w_quo;
        t_tag          w_tag;
        logic [DW-1:0] w_sub;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QB-1:0] n_quo;

        if (k == 1) begin : g_first
            assign w_valid = i_valid;
            assign w_rem   = i_num;
            assign w_den   = i_den;
            assign w_quo   = '0;
            assign w_tag   = i_tag;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_den   = r_den[k-1];
            assign w_quo   = r_quo[k-1];
            assign w_tag   = r_tag[k-1];
        end

        always_comb begin
            w_sub = DW'(w_den) << (DIV_STAGES - k);
            w_ge  = (w_rem >= w_sub);
            n_rem = w_ge ? (w_rem - w_sub) : w_rem;
            n_quo = {w_quo[QB-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den;
                r_quo[k] <= n_quo;
                r_tag[k] <= w_tag;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES];
    assign o_quo   = r_quo[DIV_STAGES];
    assign o_tag   = r_tag[DIV_STAGES];

    logic [DW-1:0] w_den_last;
    assign w_den_last = DW'(r_den[DIV_STAGES]);

    `QRM_ASSERT_NEVER(a_rem_below_den, i_clk, i_rst_n,
        r_valid[DIV_STAGES] && !r_tag[DIV_STAGES].zero && (r_rem[DIV_STAGES] >= w_den_last),
        "final remainder not below divisor")
    `QRM_ASSERT_NEVER(a_quo_max, i_clk, i_rst_n,
        r_valid[DIV_STAGES] && !r_tag[DIV_STAGES].zero && (r_quo[DIV_STAGES] > QB'(ONE_Q14)),
        "quotient above one")

endmodule

// ----- sv/quaternion_to_rotation_matrix_unit.sv -----
// Quaternion to 3x3 rotation matrix. One beat per clock is accepted while the output
// side does not stall, and one result beat per input beat is returned through
// 3 front stages (products, numerators, dividend set-up), 15 divider stages
// that resolve one rounded quotient bit each for all nine entries in parallel, and
// the output register. Entries are N * 2^14 / L rounded to nearest, ties away from
// zero, in signed Q2.14; a zero quaternion gives the identity. The translation
// travels alongside unchanged. o_ready follows i_ready or a free output register,
// so the whole pipeline holds while the output beat waits.
`include "quaternion_to_rotation_matrix_unit_macros.svh"

module quaternion_to_rotation_matrix_unit
    import qrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [QW-1:0] i_quat_x,
    input  logic signed [QW-1:0] i_quat_y,
    input  logic signed [QW-1:0] i_quat_z,
    input  logic signed [QW-1:0] i_quat_w,
    input  logic signed [TW-1:0] i_trans_x,
    input  logic signed [TW-1:0] i_trans_y,
    input  logic signed [TW-1:0] i_trans_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [QW-1:0] o_m00,
    output logic signed [QW-1:0] o_m01,
    output logic signed [QW-1:0] o_m02,
    output logic signed [QW-1:0] o_m10,
    output logic signed [QW-1:0] o_m11,
    output logic signed [QW-1:0] o_m12,
    output logic signed [QW-1:0] o_m20,
    output logic signed [QW-1:0] o_m21,
    output logic signed [QW-1:0] o_m22,
    output logic signed [TW-1:0] o_out_x,
    output logic signed [TW-1:0] o_out_y,
    output logic signed [TW-1:0] o_out_z
);

    logic             w_en;
    logic             w_front_valid;
    logic [DW-1:0]    w_num [N_ENT];
    logic [EW-1:0]    w_den;
    t_tag             w_front_tag [N_ENT];
    logic [N_ENT-1:0] w_div_valid;
    logic [QB-1:0]    w_quo [N_ENT];
    t_tag             w_div_tag [N_ENT];

    t_trans           r_side [SIDE_LAT];
    logic             r_out_valid;
    logic [QW-1:0]    r_m [N_ENT];
    t_trans           r_out_t;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    qrm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .o_valid  (w_front_valid),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_tag    (w_front_tag)
    );

    for (genvar g = 0; g < N_ENT; g++) begin : g_div
        qrm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_front_valid),
            .i_num   (w_num[g]),
            .i_den   (w_den),
            .i_tag   (w_front_tag[g]),
            .o_valid (w_div_valid[g]),
            .o_quo   (w_quo[g]),
            .o_tag   (w_div_tag[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= '{x: i_trans_x, y: i_trans_y, z: i_trans_z};
            for (int k = 1; k < SIDE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_out_t <= r_side[SIDE_LAT-1];
            for (int k = 0; k < N_ENT; k++) begin
                if (w_div_tag[0].zero) begin
                    r_m[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q14 : '0;
                end else begin
                    r_m[k] <= to_q14(w_quo[k], w_div_tag[k].neg);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid[0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_m00   = r_m[0];
    assign o_m01   = r_m[1];
    assign o_m02   = r_m[2];
    assign o_m10   = r_m[3];
    assign o_m11   = r_m[4];
    assign o_m12   = r_m[5];
    assign o_m20   = r_m[6];
    assign o_m21   = r_m[7];
    assign o_m22   = r_m[8];
    assign o_out_x = r_out_t.x;
    assign o_out_y = r_out_t.y;
    assign o_out_z = r_out_t.z;

    `QRM_ASSERT_NEVER(a_div_lanes_agree, i_clk, i_rst_n,
        (|w_div_valid) && !(&w_div_valid),
        "divider lanes out of step")
    `QRM_ASSERT_IMPL(a_entry_bounded, i_clk, i_rst_n, o_valid,
        ($signed(o_m01) >= -16384) && ($signed(o_m01) <= 16384)
            && ($signed(o_m00) >= -16384) && ($signed(o_m00) <= 16384),
        "matrix entry outside unit range")

endmodule

// ----- tb/qrm_checker.sv -----
// checker that predicts and compares every rotation matrix beat of the quaternion unit
module qrm_checker
    import qrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [QW-1:0] i_quat_x,
    input  logic signed [QW-1:0] i_quat_y,
    input  logic signed [QW-1:0] i_quat_z,
    input  logic signed [QW-1:0] i_quat_w,
    input  logic signed [TW-1:0] i_trans_x,
    input  logic signed [TW-1:0] i_trans_y,
    input  logic signed [TW-1:0] i_trans_z,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [QW-1:0] i_m00,
    input  logic signed [QW-1:0] i_m01,
    input  logic signed [QW-1:0] i_m02,
    input  logic signed [QW-1:0] i_m10,
    input  logic signed [QW-1:0] i_m11,
    input  logic signed [QW-1:0] i_m12,
    input  logic signed [QW-1:0] i_m20,
    input  logic signed [QW-1:0] i_m21,
    input  logic signed [QW-1:0] i_m22,
    input  logic signed [TW-1:0] i_pos_x,
    input  logic signed [TW-1:0] i_pos_y,
    input  logic signed [TW-1:0] i_pos_z,
    output int                   o_pending,
    output int                   o_errors
);

    localparam logic [QW-1:0] Q14_MIN = 16'h8000;
    localparam logic [QW-1:0] Q14_MAX = 16'h7fff;

    typedef logic [N_ENT-1:0][QW-1:0] t_rot;

    typedef struct packed {
        t_rot   m;
        t_trans pos;
    } t_pose_result;

    t_pose_result pending_poses[$];
    t_pose_result want;
    t_rot         got_m;
    int           pending_count = 0;
    int           error_count   = 0;
    int           results_seen  = 0;
    int           k;

    assign o_pending = pending_count;
    assign o_errors  = error_count;

    // round(num * 2^14 / len), ties away from zero, clamped
    function automatic logic [QW-1:0] scaled_entry(input longint num, input longint len);
        logic            neg;
        longint unsigned mag;
        longint unsigned q;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = ((mag << 15) + len) / (len << 1);
        if (neg) begin
            return (q > 32768) ? Q14_MIN : QW'(64'd0 - q);
        end
        return (q > 32767) ? Q14_MAX : QW'(q);
    endfunction

    function automatic t_rot rotation_from_quat(input logic signed [QW-1:0] qx,
                                                input logic signed [QW-1:0] qy,
                                                input logic signed [QW-1:0] qz,
                                                input logic signed [QW-1:0] qw);
        longint x, y, z, w, xx, yy, zz, ww, len;
        t_rot   m;
        x   = qx;
        y   = qy;
        z   = qz;
        w   = qw;
        xx  = x * x;
        yy  = y * y;
        zz  = z * z;
        ww  = w * w;
        len = xx + yy + zz + ww;
        if (len == 0) begin
            // zero quaternion falls back to identity
            m    = '0;
            m[0] = ONE_Q14;
            m[4] = ONE_Q14;
            m[8] = ONE_Q14;
        end else begin
            m[0] = scaled_entry(len - 2 * (yy + zz), len);
            m[1] = scaled_entry(2 * (x * y - z * w), len);
            m[2] = scaled_entry(2 * (x * z + y * w), len);
            m[3] = scaled_entry(2 * (x * y + z * w), len);
            m[4] = scaled_entry(len - 2 * (xx + zz), len);
            m[5] = scaled_entry(2 * (y * z - x * w), len);
            m[6] = scaled_entry(2 * (x * z - y * w), len);
            m[7] = scaled_entry(2 * (y * z + x * w), len);
            m[8] = scaled_entry(len - 2 * (xx + yy), len);
        end
        return m;
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_poses.size() == 0) begin
                    report_error($sformatf("result beat %0d with nothing pending", results_seen));
                end else begin
                    want  = pending_poses.pop_front();
                    got_m = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};
                    for (k = 0; k < N_ENT; k++) begin
                        if (got_m[k] !== want.m[k]) begin
                            report_error($sformatf("beat %0d m%0d%0d got %h want %h",
                                results_seen, k / 3, k % 3, got_m[k], want.m[k]));
                        end
                    end
                    if (i_pos_x !== want.pos.x) begin
                        report_error($sformatf("beat %0d out_x got %h want %h",
                            results_seen, i_pos_x, want.pos.x));
                    end
                    if (i_pos_y !== want.pos.y) begin
                        report_error($sformatf("beat %0d out_y got %h want %h",
                            results_seen, i_pos_y, want.pos.y));
                    end
                    if (i_pos_z !== want.pos.z) begin
                        report_error($sformatf("beat %0d out_z got %h want %h",
                            results_seen, i_pos_z, want.pos.z));
                    end
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                want.m     = rotation_from_quat(i_quat_x, i_quat_y, i_quat_z, i_quat_w);
                want.pos.x = i_trans_x;
                want.pos.y = i_trans_y;
                want.pos.z = i_trans_z;
                pending_poses.push_back(want);
            end
            pending_count <= pending_poses.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench top that drives quaternion beats and gives the verdict
module tb_top
    import qrm_pkg::*;
();

    localparam int N_RANDOM        = 400;
    localparam int HOLD_OFF_AFTER  = 120;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_AT        = 200;
    localparam int TAIL_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 200000;

    typedef enum int {READY_FREE, READY_RANDOM, READY_CADENCE} t_ready_mode;

    typedef struct packed {
        logic [QW-1:0] x;
        logic [QW-1:0] y;
        logic [QW-1:0] z;
        logic [QW-1:0] w;
        t_trans        pos;
    } t_pose_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [QW-1:0] i_quat_x;
    logic signed [QW-1:0] i_quat_y;
    logic signed [QW-1:0] i_quat_z;
    logic signed [QW-1:0] i_quat_w;
    logic signed [TW-1:0] i_trans_x;
    logic signed [TW-1:0] i_trans_y;
    logic signed [TW-1:0] i_trans_z;
    logic                 o_valid;
    logic                 i_ready;
    logic signed [QW-1:0] o_m00;
    logic signed [QW-1:0] o_m01;
    logic signed [QW-1:0] o_m02;
    logic signed [QW-1:0] o_m10;
    logic signed [QW-1:0] o_m11;
    logic signed [QW-1:0] o_m12;
    logic signed [QW-1:0] o_m20;
    logic signed [QW-1:0] o_m21;
    logic signed [QW-1:0] o_m22;
    logic signed [TW-1:0] o_out_x;
    logic signed [TW-1:0] o_out_y;
    logic signed [TW-1:0] o_out_z;

    int pending;
    int mismatches;
    int beats_sent  = 0;
    int cycle_count = 0;

    quaternion_to_rotation_matrix_unit dut (.*);

    qrm_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_trans_x   (i_trans_x),
        .i_trans_y   (i_trans_y),
        .i_trans_z   (i_trans_z),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_m00       (o_m00),
        .i_m01       (o_m01),
        .i_m02       (o_m02),
        .i_m10       (o_m10),
        .i_m11       (o_m11),
        .i_m12       (o_m12),
        .i_m20       (o_m20),
        .i_m21       (o_m21),
        .i_m22       (o_m22),
        .i_pos_x     (o_out_x),
        .i_pos_y     (o_out_y),
        .i_pos_z     (o_out_z),
        .o_pending   (pending),
        .o_errors    (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_pose_beat pose(input int x, input int y, input int z, input int w,
                                        input logic [TW-1:0] tx, input logic [TW-1:0] ty,
                                        input logic [TW-1:0] tz);
        t_pose_beat b;
        b.x     = QW'(x);
        b.y     = QW'(y);
        b.z     = QW'(z);
        b.w     = QW'(w);
        b.pos.x = tx;
        b.pos.y = ty;
        b.pos.z = tz;
        return b;
    endfunction

    function automatic logic [TW-1:0] random_position();
        if ($urandom_range(0, 7) != 0) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic t_pose_beat random_pose();
        t_pose_beat    b;
        logic [QW-1:0] c [4];
        int            roll;
        int            i;
        roll = $urandom_range(0, 19);
        for (i = 0; i < 4; i++) begin
            if (roll < 10) begin
                c[i] = QW'($urandom);
            end else if (roll < 12) begin
                // tiny components make rounding ties common
                c[i] = QW'($urandom_range(0, 7)) - QW'(4);
            end else if (roll < 14) begin
                c[i] = $urandom_range(0, 1) ? QW'($urandom) : '0;
            end else if (roll < 16) begin
                case ($urandom_range(0, 4))
                    0: c[i] = 16'h8000;
                    1: c[i] = 16'h7fff;
                    2: c[i] = 16'h0000;
                    3: c[i] = 16'hffff;
                    default: c[i] = 16'h0001;
                endcase
            end else if (roll < 19) begin
                c[i] = QW'($urandom_range(0, 16384));
                if ($urandom_range(0, 1) != 0) begin
                    c[i] = QW'(0) - c[i];
                end
            end else begin
                c[i] = '0;
            end
        end
        b = pose(int'(c[0]), int'(c[1]), int'(c[2]), int'(c[3]), random_position(),
                 random_position(), random_position());
        return b;
    endfunction

    task automatic drive_beat(input t_pose_beat b);
        i_quat_x  <= b.x;
        i_quat_y  <= b.y;
        i_quat_z  <= b.z;
        i_quat_w  <= b.w;
        i_trans_x <= b.pos.x;
        i_trans_y <= b.pos.y;
        i_trans_z <= b.pos.z;
        i_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // output side stall pattern, with one long hold-off to back up the pipeline
    initial begin
        t_ready_mode mode;
        int          seg_len;
        int          period;
        int          low_len;
        int          k;
        bit          held;
        held = 1'b0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && beats_sent >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                mode    = t_ready_mode'($urandom_range(0, 2));
                seg_len = $urandom_range(8, 60);
                period  = $urandom_range(2, 7);
                low_len = $urandom_range(1, period - 1);
                for (k = 0; k < seg_len; k++) begin
                    case (mode)
                        READY_FREE:   i_ready <= 1'b1;
                        READY_RANDOM: i_ready <= ($urandom_range(0, 9) < 6);
                        default:      i_ready <= ((k % period) >= low_len);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL quaternion_to_rotation_matrix_unit");
        $finish;
    end

    initial begin
        int  n;
        int  k;
        int  burst;
        int  gap;
        bit  drained;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_quat_x  <= '0;
        i_quat_y  <= '0;
        i_quat_z  <= '0;
        i_quat_w  <= '0;
        i_trans_x <= '0;
        i_trans_y <= '0;
        i_trans_z <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats: zero, axes, extremes, unnormalized and rounding cases
        drive_beat(pose(0, 0, 0, 0, 0, 0, 0));
        drive_beat(pose(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
        drive_beat(pose(0, 0, 0, 16384, 32'h0001_0000, 32'hffff_0000, 0));
        drive_beat(pose(0, 0, 0, -16384, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001));
        drive_beat(pose(16384, 0, 0, 0, 1, 2, 3));
        drive_beat(pose(0, 16384, 0, 0, -1, -2, -3));
        drive_beat(pose(0, 0, 16384, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f));
        drive_beat(pose(32767, 32767, 32767, 32767, 32'hffff_ffff, 0, 32'h7fff_ffff));
        drive_beat(pose(-32768, -32768, -32768, -32768, 0, 32'h8000_0000, 0));
        drive_beat(pose(32767, -32768, 32767, -32768, 32'h1234_5678, 0, 32'h8765_4321));
        drive_beat(pose(-32768, 0, 0, 0, 0, 0, 0));
        drive_beat(pose(1, 0, 0, 0, 0, 0, 0));
        drive_beat(pose(0, 0, 0, -1, 0, 0, 0));
        drive_beat(pose(1, 1, 1, 1, 0, 0, 0));
        drive_beat(pose(1, -1, 1, -1, 0, 0, 0));
        drive_beat(pose(3, 4, 0, 0, 0, 0, 0));
        drive_beat(pose(8192, 8192, 8192, 8192, 0, 0, 0));
        drive_beat(pose(11585, 0, 0, 11585, 0, 0, 0));
        drive_beat(pose(1, 2, 3, 4, 0, 0, 0));
        drive_beat(pose(-4, -3, -2, -1, 0, 0, 0));
        drive_beat(pose(0, 0, 32767, 32767, 0, 0, 0));
        drain_results();

        n       = 0;
        drained = 1'b0;
        while (n < N_RANDOM) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (k = 0; k < burst && n < N_RANDOM; k++) begin
                drive_beat(random_pose());
                n++;
            end
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            if (!drained && n >= DRAIN_AT) begin
                drained = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS quaternion_to_rotation_matrix_unit");
        end else begin
            $display("FAIL quaternion_to_rotation_matrix_unit");
        end
        $finish;
    end

endmodule
